// ===== design/iolh_pkg.sv =====
// Package for the I/O latency histogram: field widths, codes, command and
// status structs shared by the controller and the datapath.
// No dependencies.
package iolh_pkg;

  // Number of request tags the tracker keeps
  localparam int TAG_COUNT = 256;
  // Tag field is eight bits wide, so at most 256 table rows are reachable
  localparam int TABLE_DEPTH = (TAG_COUNT < 256) ? TAG_COUNT : 256;
  localparam int TABLE_AW = $clog2(TABLE_DEPTH);

  localparam int TIME_W = 64;
  localparam int COUNT_W = 64;
  localparam int NUM_BINS = 64;
  localparam int BIN_W = 6;
  localparam int LOG_STEPS = 31;
  localparam int NS_PER_US = 1000;

  typedef enum logic [1:0] {
    OP_ISSUE    = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_READ     = 2'd2,
    OP_SPARE    = 2'd3
  } op_t;

  localparam logic [7:0] REQ_READ = 8'h00;
  localparam logic [7:0] REQ_WRITE = 8'h01;

  typedef enum logic [2:0] {
    ST_ISSUED    = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_BINNED    = 3'd2,
    ST_UNMATCHED = 3'd3,
    ST_READ      = 3'd4
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load;          // capture the input item
    logic    tbl_wr;        // record the issue in the tag table
    logic    tbl_rd;        // fetch the entry and drop its valid bit
    logic    diff_en;       // register the elapsed time
    logic    hist_rd_calc;  // read the histogram at the computed bin
    logic    hist_rd_idx;   // read the histogram at the requested bin
    logic    hist_upd;      // write back the incremented count
    logic    res_en;        // load the result registers
    status_t res_status;
  } iolh_cmd_t;

  // Decoded item state reported back to the controller
  typedef struct packed {
    logic issue_ok;
    logic complete;
    logic read_bin;
    logic hit;
  } iolh_sts_t;

  // Elapsed ns at or above which the microsecond latency exceeds 2^i
  function automatic logic [TIME_W-1:0] bin_threshold(input int i);
    logic [TIME_W-1:0] pow;
    pow = TIME_W'(1) << i;
    return TIME_W'(NS_PER_US) * (pow + TIME_W'(1));
  endfunction

endpackage

// ===== design/iolh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iolh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/iolh_ctrl.sv =====
// Controller for the I/O latency histogram: sequences one item through
// decode, table lookup, binning and histogram update. Uses iolh_pkg.
module iolh_ctrl
  import iolh_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  iolh_sts_t sts,
  output iolh_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_LOOKUP = 6'b000100,
    S_BIN    = 6'b001000,
    S_COUNT  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_DONE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.res_status = ST_IGNORED;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts.issue_ok) begin
          cmd.tbl_wr = 1'b1;
          cmd.res_en = 1'b1;
          cmd.res_status = ST_ISSUED;
          state_next = S_DONE;
        end else if (sts.complete && sts.hit) begin
          cmd.tbl_rd = 1'b1;
          state_next = S_LOOKUP;
        end else if (sts.complete) begin
          cmd.res_en = 1'b1;
          cmd.res_status = ST_UNMATCHED;
          state_next = S_DONE;
        end else if (sts.read_bin) begin
          cmd.hist_rd_idx = 1'b1;
          state_next = S_COUNT;
        end else begin
          cmd.res_en = 1'b1;
          cmd.res_status = ST_IGNORED;
          state_next = S_DONE;
        end
      end
      S_LOOKUP: begin
        cmd.diff_en = 1'b1;
        state_next = S_BIN;
      end
      S_BIN: begin
        cmd.hist_rd_calc = 1'b1;
        state_next = S_COUNT;
      end
      S_COUNT: begin
        cmd.res_en = 1'b1;
        if (sts.read_bin) begin
          cmd.res_status = ST_READ;
        end else begin
          cmd.hist_upd = 1'b1;
          cmd.res_status = ST_BINNED;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/iolh_dp.sv =====
// Datapath for the I/O latency histogram: input capture, tag table with
// valid bits, latency binning and the histogram counters.
// Uses iolh_pkg and iolh_ram.
module iolh_dp
  import iolh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  iolh_cmd_t         cmd,
  output iolh_sts_t         sts,
  input  logic [1:0]        op,
  input  logic [7:0]        tag,
  input  logic [7:0]        request_code,
  input  logic [TIME_W-1:0] time_ns,
  input  logic [BIN_W-1:0]  bin_index,
  output logic [2:0]        status,
  output logic [BIN_W-1:0]  bin,
  output logic [COUNT_W-1:0] count
);

  // Captured item
  logic [1:0]        op_q;
  logic [7:0]        tag_q;
  logic [7:0]        code_q;
  logic [TIME_W-1:0] time_q;
  logic [BIN_W-1:0]  bidx_q;

  // Binning and result registers
  logic [TIME_W-1:0]  diff_q;
  logic               wr_q;
  logic [BIN_W-1:0]   bin_q;
  status_t            status_q;
  logic [BIN_W-1:0]   bin_out_q;
  logic [COUNT_W-1:0] count_q;

  // Valid bits, cleared at reset
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [NUM_BINS-1:0]    hist_valid;

  logic [TABLE_AW-1:0]  tidx;
  logic                 tag_ok;
  logic [TIME_W:0]      tbl_wdata;
  logic [TIME_W:0]      tbl_rdata;
  logic [LOG_STEPS-1:0] above;
  logic [BIN_W-1:0]     calc_bin;
  logic                 hist_re;
  logic [BIN_W-1:0]     hist_raddr;
  logic [COUNT_W-1:0]   hist_rdata;
  logic [COUNT_W-1:0]   cur_count;
  logic [COUNT_W-1:0]   inc_count;

  // Capture the item on accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= op;
      tag_q <= tag;
      code_q <= request_code;
      time_q <= time_ns;
      bidx_q <= bin_index;
    end
  end

  // Decode the captured item
  assign tidx = tag_q[TABLE_AW-1:0];
  assign tag_ok = (32'(tag_q) < TAG_COUNT);
  assign sts.issue_ok = (op_q == OP_ISSUE) && tag_ok &&
                        ((code_q == REQ_READ) || (code_q == REQ_WRITE));
  assign sts.complete = (op_q == OP_COMPLETE) && tag_ok;
  assign sts.read_bin = (op_q == OP_READ);
  assign sts.hit = entry_valid[tidx];

  // Tag table: start time with the write flag on top
  assign tbl_wdata = {(code_q == REQ_WRITE), time_q};

  iolh_ram #(
    .WIDTH (TIME_W + 1),
    .DEPTH (TABLE_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (cmd.tbl_wr),
    .waddr (tidx),
    .wdata (tbl_wdata),
    .re    (cmd.tbl_rd),
    .raddr (tidx),
    .rdata (tbl_rdata)
  );

  // Set on issue, drop on a matched completion
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.tbl_wr) begin
      entry_valid[tidx] <= 1'b1;
    end else if (cmd.tbl_rd) begin
      entry_valid[tidx] <= 1'b0;
    end
  end

  // Elapsed time, wrapping
  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      diff_q <= time_q - tbl_rdata[TIME_W-1:0];
      wr_q <= tbl_rdata[TIME_W];
    end
  end

  // Compare elapsed ns against each power-of-two microsecond boundary
  always_comb begin
    for (int i = 0; i < LOG_STEPS; i++) begin
      above[i] = (diff_q >= bin_threshold(i));
    end
  end

  assign calc_bin = {wr_q, (BIN_W - 1)'($countones(above))};

  // Histogram read address: computed bin or requested bin
  assign hist_re = cmd.hist_rd_calc | cmd.hist_rd_idx;
  assign hist_raddr = cmd.hist_rd_calc ? calc_bin : bidx_q;

  always_ff @(posedge clk) begin
    if (hist_re) begin
      bin_q <= hist_raddr;
    end
  end

  iolh_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_BINS)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.hist_upd),
    .waddr (bin_q),
    .wdata (inc_count),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // A counter never written reads as zero
  assign cur_count = hist_valid[bin_q] ? hist_rdata : '0;
  assign inc_count = cur_count + COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
    end else if (cmd.hist_upd) begin
      hist_valid[bin_q] <= 1'b1;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      status_q <= cmd.res_status;
      unique case (cmd.res_status)
        ST_BINNED: begin
          bin_out_q <= bin_q;
          count_q <= inc_count;
        end
        ST_READ: begin
          bin_out_q <= bin_q;
          count_q <= cur_count;
        end
        default: begin
          bin_out_q <= '0;
          count_q <= '0;
        end
      endcase
    end
  end

  assign status = status_q;
  assign bin = bin_out_q;
  assign count = count_q;

endmodule

// ===== design/io_latency_histogram.sv =====
// Top level of the I/O latency histogram: controller plus datapath.
// Uses iolh_pkg, iolh_ctrl, iolh_dp.
//
//   channel  handshake             payload
//   input    in_valid / in_ready   op, tag, request_code, time_ns, bin_index
//   output   out_valid / out_ready status, bin, count
//
// One item at a time. After decode, an issue, an ignored op or an unmatched
// completion goes straight to the result; a bin read first takes a histogram
// read; a matched completion takes table read, elapsed-time register, bin
// compare and histogram read-modify-write, in that order. The next item is
// taken the cycle after the result is accepted. rst clears the tag valid
// bits and the histogram (by valid bits) at once; there is no clearing
// pass. A stalled result holds until out_ready.
module io_latency_histogram
  import iolh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [7:0]         tag,
  input  logic [7:0]         request_code,
  input  logic [TIME_W-1:0]  time_ns,
  input  logic [BIN_W-1:0]   bin_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [BIN_W-1:0]   bin,
  output logic [COUNT_W-1:0] count
);

  iolh_cmd_t cmd;
  iolh_sts_t sts;

  iolh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  iolh_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .op           (op),
    .tag          (tag),
    .request_code (request_code),
    .time_ns      (time_ns),
    .bin_index    (bin_index),
    .status       (status),
    .bin          (bin),
    .count        (count)
  );

  // Never take a new item while a result is pending
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  // Drop ready straight after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after accept");

  // Results without a bin carry zero bin and count
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ISSUED || status == ST_IGNORED ||
                  status == ST_UNMATCHED) |-> bin == '0 && count == '0)
    else $error("non-zero bin or count on a result without a bin");

  // Never write the table and a histogram counter together
  a_single_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.tbl_wr && cmd.hist_upd))
    else $error("table and histogram written in the same cycle");

endmodule
